FILE: hdl/rpma_pkg.sv
// rpma_pkg: shared widths, constants, op codes, states and the divider request/response
// structs for the repetition penalty mask block.
// no dependencies
`default_nettype none

package rpma_pkg;

	localparam int VOCAB      = 32768;
	localparam int ADDR_W     = $clog2(VOCAB);

	localparam int OP_W       = 2;
	localparam int TOK_W      = 15;
	localparam int LOGIT_W    = 32;
	localparam int PEN_W      = 24;
	localparam int SUS_W      = 17;
	localparam int DEC_W      = 16;
	localparam int POS_W      = 17;
	localparam int CUR_W      = 26;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int PROD_W     = LOGIT_W + PEN_W;

	// divider: 48-bit dividend, 24-bit divisor, 32 quotient bits, two bits a step
	localparam int DVD_W      = 48;
	localparam int DVS_W      = 24;
	localparam int QUO_W      = 32;
	localparam int DIV_STEPS  = QUO_W / 2;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [PEN_W-1:0]   ONE_Q16   = PEN_W'(65536);
	localparam logic [POS_W-1:0]   POS_MAX   = '1;
	localparam logic [LOGIT_W-1:0] LOGIT_MAX = {1'b0, {(LOGIT_W-1){1'b1}}};
	localparam logic [LOGIT_W-1:0] LOGIT_MIN = {1'b1, {(LOGIT_W-1){1'b0}}};

	localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_MAX = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY       = CFG_IDX_W'(2);

	typedef enum logic [OP_W-1:0] {
		OP_START = 2'd0,
		OP_TOKEN = 2'd1,
		OP_APPLY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_TOK_WR,
		S_APL_RD,
		S_APL_DIV,
		S_APL_MUL,
		S_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic             ovf;
		logic [QUO_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/rpma_mask_ram.sv
// rpma_mask_ram: single-port-write, single-port-read synchronous RAM for the mask store,
// read data registered. no package dependency
`default_nettype none

module rpma_mask_ram #(
	parameter int DEPTH  = 32768,
	parameter int WIDTH  = 24,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/rpma_div.sv
// rpma_div: iterative restoring divider, two quotient bits per cycle, shared between
// the decay step and the logit division. depends on rpma_pkg
`default_nettype none

module rpma_div
	import rpma_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic                 ovf_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [QUO_W-1:0]     quo_q;

	logic [DVD_W-QUO_W-1:0] hi;
	logic                   hi_ge;
	logic [DVS_W:0]         t1, r1, t2, r2;
	logic                   ge1, ge2;

	always_comb begin
		hi    = req.dividend[DVD_W-1:QUO_W];
		// quotient would not fit in QUO_W bits (also catches a zero divisor)
		hi_ge = DVS_W'(hi) >= req.divisor;
		t1    = {rem_q, quo_q[QUO_W-1]};
		ge1   = t1 >= {1'b0, dvs_q};
		r1    = ge1 ? t1 - {1'b0, dvs_q} : t1;
		t2    = {r1[DVS_W-1:0], quo_q[QUO_W-2]};
		ge2   = t2 >= {1'b0, dvs_q};
		r2    = ge2 ? t2 - {1'b0, dvs_q} : t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				ovf_q  <= hi_ge;
				busy_q <= !hi_ge;
				done_q <= hi_ge;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// low dividend bits shift out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= req.divisor;
			rem_q <= DVS_W'(hi);
			quo_q <= req.dividend[QUO_W-1:0];
		end else if (busy_q) begin
			rem_q <= r2[DVS_W-1:0];
			quo_q <= {quo_q[QUO_W-3:0], ge1, ge2};
		end
	end

	always_comb begin
		rsp.busy = busy_q;
		rsp.done = done_q;
		rsp.ovf  = ovf_q;
		rsp.quot = quo_q;
	end

endmodule

`default_nettype wire

FILE: hdl/repetition_penalty_mask_apply_top.sv
// repetition_penalty_mask_apply_top: per-token penalty mask in a synchronous RAM,
// decayed penalty tracking and logit scaling. depends on rpma_pkg, rpma_mask_ram, rpma_div
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------
//   cfg      | cfg_we             | cfg_index, cfg_data
//   in       | in_valid/in_ready  | op, token, logit
//   out      | out_valid/out_ready| penalty, logit_out
//
// token: mask read, compare and write back; apply by division waits on the 16 steps of the
// shared divider unless the quotient overflows. start: a clearing pass over the mask RAM,
// one entry a cycle. after reset the same clearing pass runs over every entry before
// in_ready rises.
// one transaction at a time; a new one is taken while the last result waits in the
// output register, and a stalled output holds the engine only at its final step.
`default_nettype none

module repetition_penalty_mask_apply_top
	import rpma_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [OP_W-1:0]           op,
	input  logic [TOK_W-1:0]          token,
	input  logic signed [LOGIT_W-1:0] logit,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [PEN_W-1:0]          penalty,
	output logic signed [LOGIT_W-1:0] logit_out
);

	// configuration
	logic [PEN_W-1:0] pmax_q;
	logic [SUS_W-1:0] sustain_q;
	logic [DEC_W-1:0] decay_q;

	// control state
	state_t              state_q, state_d;
	logic [POS_W-1:0]    pos_q;
	logic signed [CUR_W-1:0] cur_q;
	logic signed [CUR_W-1:0] dv_q;
	logic                dv_pend_q;
	logic [ADDR_W-1:0]   clr_cnt_q;
	logic                out_valid_q;

	// transaction payload
	logic [TOK_W-1:0]    tok_q;
	logic [LOGIT_W-1:0]  logit_q;
	logic                rng_q;
	logic                win_q;
	logic [PEN_W-1:0]    v_q;
	logic                dvneg_q;
	logic [PROD_W-1:0]   prod_q;
	logic [PEN_W-1:0]    res_pen_q;
	logic [LOGIT_W-1:0]  res_logit_q;
	logic [PEN_W-1:0]    penalty_q;
	logic [LOGIT_W-1:0]  logit_out_q;

	// mask RAM
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [PEN_W-1:0]    mem_wdata;
	logic                mem_re;
	logic [PEN_W-1:0]    mem_rdata;

	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic                accept;
	op_t                 op_in;
	logic                slot_free;
	logic                clr_last;
	logic                out_load;
	logic [POS_W-1:0]    pos_n;
	logic                sus_neg;
	logic [SUS_W-2:0]    sus_mag;
	logic [POS_W:0]      win_lim;
	logic                tok_win;
	logic                tok_add;
	logic [PEN_W-1:0]    v_clamp;
	logic signed [CUR_W:0] cur_sum;
	logic signed [CUR_W-1:0] cur_sat;
	logic                dvneg;
	logic [PEN_W-1:0]    dv_num;
	logic                lpos;
	logic [LOGIT_W-1:0]  mag;
	logic [PEN_W-1:0]    p_sel;
	logic [PROD_W-17:0]  mq;
	logic [LOGIT_W-1:0]  mneg;

	always_comb begin
		accept    = in_valid && in_ready;
		op_in     = op_t'(op);
		slot_free = !out_valid_q || out_ready;
		clr_last  = clr_cnt_q == ADDR_W'(VOCAB - 1);

		// window and ramp for the token being taken
		pos_n   = (pos_q != POS_MAX) ? pos_q + POS_W'(1) : pos_q;
		sus_neg = sustain_q[SUS_W-1];
		sus_mag = sustain_q[SUS_W-2:0];
		win_lim = (POS_W+1)'(sus_mag) + (POS_W+1)'(decay_q);
		tok_win = sus_neg || ((POS_W+1)'(pos_n) <= win_lim);
		tok_add = !sus_neg && (pos_n > POS_W'(sus_mag));

		if (cur_q[CUR_W-1]) begin
			v_clamp = '0;
		end else if (|cur_q[CUR_W-2:PEN_W]) begin
			v_clamp = '1;
		end else begin
			v_clamp = cur_q[PEN_W-1:0];
		end

		// saturating accumulate; once past either clamp bound it never comes back
		cur_sum = (CUR_W+1)'(cur_q) + (CUR_W+1)'(dv_q);
		if (cur_sum[CUR_W] != cur_sum[CUR_W-1]) begin
			cur_sat = cur_sum[CUR_W] ? {1'b1, {(CUR_W-1){1'b0}}} : {1'b0, {(CUR_W-1){1'b1}}};
		end else begin
			cur_sat = cur_sum[CUR_W-1:0];
		end

		dvneg  = pmax_q > ONE_Q16;
		dv_num = dvneg ? pmax_q - ONE_Q16 : ONE_Q16 - pmax_q;

		lpos  = !logit_q[LOGIT_W-1] && (logit_q != '0);
		mag   = ~logit_q + LOGIT_W'(1);
		p_sel = rng_q ? mem_rdata : ONE_Q16;

		mq   = prod_q[PROD_W-1:16];
		mneg = (|mq[PROD_W-17:LOGIT_W-1]) ? LOGIT_MIN : mq[LOGIT_W-1:0];
	end

	always_comb begin
		if (state_q == S_APL_RD) begin
			div_req.start    = lpos;
			div_req.dividend = {logit_q, {(DVD_W-LOGIT_W){1'b0}}};
			div_req.divisor  = p_sel;
		end else begin
			div_req.start    = accept && (op_in == OP_START) && (decay_q != '0);
			div_req.dividend = DVD_W'(dv_num);
			div_req.divisor  = DVS_W'(decay_q);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmax_q    <= ONE_Q16;
			sustain_q <= '0;
			decay_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PENALTY_MAX: pmax_q    <= cfg_data[PEN_W-1:0];
				CFG_SUSTAIN:     sustain_q <= cfg_data[SUS_W-1:0];
				CFG_DECAY:       decay_q   <= cfg_data[DEC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ADDR_W'(tok_q);
		mem_wdata = v_q;
		mem_re    = accept;
		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = ONE_Q16;
				if (clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (op_in)
						OP_START: state_d = S_CLEAR;
						OP_TOKEN: state_d = S_TOK_WR;
						OP_APPLY: state_d = S_APL_RD;
						default:  state_d = S_OUT;
					endcase
				end
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = ONE_Q16;
				if (clr_last && !dv_pend_q) state_d = S_OUT;
			end
			S_TOK_WR: begin
				mem_we = win_q && rng_q && (v_q > mem_rdata);
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end else begin
					state_d = S_OUT;
				end
			end
			S_APL_RD: begin
				state_d = lpos ? S_APL_DIV : S_APL_MUL;
			end
			S_APL_DIV: begin
				if (div_rsp.done) state_d = S_OUT;
			end
			S_APL_MUL: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			cur_q       <= '0;
			dv_q        <= '0;
			dv_pend_q   <= 1'b0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_INIT || state_q == S_CLEAR) begin
				clr_cnt_q <= clr_last ? '0 : clr_cnt_q + ADDR_W'(1);
			end
			if (accept) begin
				unique case (op_in)
					OP_START: begin
						pos_q     <= '0;
						cur_q     <= CUR_W'(pmax_q);
						clr_cnt_q <= '0;
						dv_pend_q <= decay_q != '0;
						if (decay_q == '0) dv_q <= '0;
					end
					OP_TOKEN: begin
						pos_q <= pos_n;
						if (tok_win && tok_add) cur_q <= cur_sat;
					end
					default: ;
				endcase
			end
			if (div_rsp.done && dv_pend_q) begin
				dv_pend_q <= 1'b0;
				dv_q      <= dvneg_q ? -CUR_W'(div_rsp.quot[PEN_W-1:0])
				                     : CUR_W'(div_rsp.quot[PEN_W-1:0]);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_q       <= token;
			logit_q     <= logit;
			rng_q       <= 32'(token) < 32'(VOCAB);
			win_q       <= tok_win;
			v_q         <= v_clamp;
			dvneg_q     <= dvneg;
			res_pen_q   <= '0;
			res_logit_q <= '0;
		end
		if (state_q == S_APL_RD) begin
			res_pen_q <= p_sel;
			prod_q    <= PROD_W'(mag) * PROD_W'(p_sel);
		end
		if (state_q == S_APL_MUL) begin
			res_logit_q <= ~mneg + LOGIT_W'(1);
		end
		if (state_q == S_APL_DIV && div_rsp.done) begin
			res_logit_q <= (div_rsp.ovf || div_rsp.quot[QUO_W-1]) ? LOGIT_MAX
			                                                    : div_rsp.quot;
		end
		if (out_load) begin
			penalty_q   <= res_pen_q;
			logit_out_q <= res_logit_q;
		end
	end

	rpma_mask_ram #(
		.DEPTH (VOCAB),
		.WIDTH (PEN_W)
	) u_mask_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (ADDR_W'(token)),
		.rdata (mem_rdata)
	);

	rpma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_valid = out_valid_q;
	assign penalty   = penalty_q;
	assign logit_out = logit_out_q;

	// engine is busy the cycle after any transaction is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again right after a transaction");

	// shared divider never restarted while iterating
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// decay step division must be finished before an apply can use the divider
	a_no_dv_in_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APL_RD) |-> !dv_pend_q)
		else $error("apply reached with decay step still pending");

	// a finished result with a free slot always reaches the output
	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && slot_free) |=> out_valid)
		else $error("result lost at the output register");

endmodule

`default_nettype wire
